// File: rtl/tpfc_pkg.sv
package tpfc_pkg;

    localparam int PACKET_BYTES = 44;
    localparam int PAYLOAD_LEN  = PACKET_BYTES - 4;
    localparam int CNT_W        = $clog2(PAYLOAD_LEN + 1);

    localparam int NUM_REGS  = 3;
    localparam int CFG_IDX_W = $clog2(NUM_REGS);

    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_A_ID    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_B_ID    = CFG_IDX_W'(2);

    localparam logic [7:0] START_MARKER_RST = 8'hFE;
    localparam logic [7:0] TYPE_A_ID_RST    = 8'hAA;
    localparam logic [7:0] TYPE_B_ID_RST    = 8'hBB;
    localparam logic [7:0] CRC_POLY         = 8'h8C;
    localparam logic [7:0] CRC_INIT         = 8'h00;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0]       data;
        logic             start;
        logic             close;
        logic [7:0]       marker;
        logic [7:0]       id;
        logic [7:0]       seq;
        logic [CNT_W-1:0] pad;
    } entry_t;

    typedef enum logic [5:0] {
        PH_ENTRY = 6'b000001,
        PH_ID    = 6'b000010,
        PH_SEQ   = 6'b000100,
        PH_DATA  = 6'b001000,
        PH_PAD   = 6'b010000,
        PH_CRC   = 6'b100000
    } phase_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                               input logic [7:0] data_in);
        logic [7:0] crc;
        logic [7:0] d;
        logic       mix;
        crc = crc_in;
        d   = data_in;
        for (int i = 0; i < 8; i++)
        begin
            mix = crc[0] ^ d[0];
            crc = crc >> 1;
            if (mix)
            begin
                crc = crc ^ CRC_POLY;
            end
            d = d >> 1;
        end
        return crc;
    endfunction

endpackage

// File: rtl/tpfc_front.sv
module tpfc_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [tpfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           payload_valid,
    output logic                           payload_ready,
    input  logic [7:0]                     payload_byte,
    input  logic                           payload_last,
    input  logic                           q_full,
    output logic                           q_push,
    output tpfc_pkg::entry_t               q_entry
);

    logic [7:0] start_marker_reg;
    logic [7:0] type_a_id_reg;
    logic [7:0] type_b_id_reg;

    logic                       in_packet_reg, in_packet_next;
    logic [tpfc_pkg::CNT_W-1:0] count_reg, count_next;
    logic [7:0]                 seq_reg, seq_next;
    logic                       next_b_reg, next_b_next;

    logic                       start;
    logic                       close;
    logic [tpfc_pkg::CNT_W-1:0] count_after;
    logic [7:0]                 seq_hdr;

    assign payload_ready = !q_full;
    assign q_push        = payload_valid && !q_full;

    always_comb
    begin
        start       = !in_packet_reg;
        count_after = (start ? '0 : count_reg) + tpfc_pkg::CNT_W'(1);
        close       = payload_last
                      || (count_after >= tpfc_pkg::CNT_W'(tpfc_pkg::PAYLOAD_LEN));
        seq_hdr     = seq_reg + 8'd1;

        q_entry.data   = payload_byte;
        q_entry.start  = start;
        q_entry.close  = close;
        q_entry.marker = start_marker_reg;
        q_entry.id     = next_b_reg ? type_b_id_reg : type_a_id_reg;
        q_entry.seq    = seq_hdr;
        q_entry.pad    = tpfc_pkg::CNT_W'(tpfc_pkg::PAYLOAD_LEN) - count_after;

        in_packet_next = in_packet_reg;
        count_next     = count_reg;
        seq_next       = seq_reg;
        next_b_next    = next_b_reg;
        if (q_push)
        begin
            if (start)
            begin
                seq_next = seq_hdr;
            end
            if (close)
            begin
                in_packet_next = 1'b0;
                count_next     = '0;
                next_b_next    = !next_b_reg;
            end
            else
            begin
                in_packet_next = 1'b1;
                count_next     = count_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg <= 1'b0;
            count_reg     <= '0;
            seq_reg       <= '0;
            next_b_reg    <= 1'b0;
        end
        else
        begin
            in_packet_reg <= in_packet_next;
            count_reg     <= count_next;
            seq_reg       <= seq_next;
            next_b_reg    <= next_b_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= tpfc_pkg::START_MARKER_RST;
            type_a_id_reg    <= tpfc_pkg::TYPE_A_ID_RST;
            type_b_id_reg    <= tpfc_pkg::TYPE_B_ID_RST;
        end
        else if (cfg_write)
        begin
            if (cfg_index == tpfc_pkg::REG_START_MARKER)
            begin
                start_marker_reg <= cfg_data;
            end
            else if (cfg_index == tpfc_pkg::REG_TYPE_A_ID)
            begin
                type_a_id_reg <= cfg_data;
            end
            else if (cfg_index == tpfc_pkg::REG_TYPE_B_ID)
            begin
                type_b_id_reg <= cfg_data;
            end
        end
    end

endmodule

// File: rtl/tpfc_queue.sv
module tpfc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tpfc_pkg::entry_t  push_entry,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output tpfc_pkg::entry_t  head_entry
);

    tpfc_pkg::entry_t mem [tpfc_pkg::QUEUE_DEPTH];

    logic [tpfc_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tpfc_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tpfc_pkg::QCNT_W-1:0] cnt_reg, cnt_next;

    logic do_push;
    logic do_pop;

    assign full       = (cnt_reg == tpfc_pkg::QCNT_W'(tpfc_pkg::QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == tpfc_pkg::QPTR_W'(tpfc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + tpfc_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == tpfc_pkg::QPTR_W'(tpfc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + tpfc_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + tpfc_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - tpfc_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: rtl/tpfc_back.sv
module tpfc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  tpfc_pkg::entry_t  head_entry,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              packet_end
);

    tpfc_pkg::phase_t           phase_reg, phase_next;
    logic [tpfc_pkg::CNT_W-1:0] pad_reg, pad_next;
    logic [7:0]                 crc_reg, crc_next;
    logic                       out_valid_reg, out_valid_next;
    logic [7:0]                 out_byte_reg;
    logic                       packet_end_reg;

    logic                       adv;
    logic [7:0]                 emit_byte;
    logic                       emit_end;
    logic                       take;
    tpfc_pkg::phase_t           after_data;

    assign adv        = head_valid && (!out_valid_reg || out_ready);
    assign pop        = adv && take;
    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign packet_end = packet_end_reg;

    always_comb
    begin
        if (!head_entry.close)
        begin
            after_data = tpfc_pkg::PH_ENTRY;
        end
        else if (head_entry.pad != '0)
        begin
            after_data = tpfc_pkg::PH_PAD;
        end
        else
        begin
            after_data = tpfc_pkg::PH_CRC;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        pad_next   = pad_reg;
        emit_byte  = '0;
        emit_end   = 1'b0;
        take       = 1'b0;
        unique case (phase_reg)
            tpfc_pkg::PH_ENTRY:
            begin
                if (head_entry.start)
                begin
                    emit_byte  = head_entry.marker;
                    phase_next = tpfc_pkg::PH_ID;
                end
                else
                begin
                    emit_byte  = head_entry.data;
                    phase_next = after_data;
                    pad_next   = head_entry.pad;
                    take       = !head_entry.close;
                end
            end
            tpfc_pkg::PH_ID:
            begin
                emit_byte  = head_entry.id;
                phase_next = tpfc_pkg::PH_SEQ;
            end
            tpfc_pkg::PH_SEQ:
            begin
                emit_byte  = head_entry.seq;
                phase_next = tpfc_pkg::PH_DATA;
            end
            tpfc_pkg::PH_DATA:
            begin
                emit_byte  = head_entry.data;
                phase_next = after_data;
                pad_next   = head_entry.pad;
                take       = !head_entry.close;
            end
            tpfc_pkg::PH_PAD:
            begin
                emit_byte = '0;
                pad_next  = pad_reg - tpfc_pkg::CNT_W'(1);
                if (pad_reg == tpfc_pkg::CNT_W'(1))
                begin
                    phase_next = tpfc_pkg::PH_CRC;
                end
            end
            tpfc_pkg::PH_CRC:
            begin
                emit_byte  = crc_reg;
                emit_end   = 1'b1;
                take       = 1'b1;
                phase_next = tpfc_pkg::PH_ENTRY;
            end
            default:
            begin
                phase_next = tpfc_pkg::PH_ENTRY;
            end
        endcase

        crc_next = emit_end ? tpfc_pkg::CRC_INIT
                            : tpfc_pkg::crc8_update(crc_reg, emit_byte);

        if (adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= tpfc_pkg::PH_ENTRY;
            pad_reg       <= '0;
            crc_reg       <= tpfc_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                phase_reg <= phase_next;
                pad_reg   <= pad_next;
                crc_reg   <= crc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_byte_reg   <= emit_byte;
            packet_end_reg <= emit_end;
        end
    end

endmodule

// File: rtl/telemetry_packet_framer_crc8_unit.sv
// Telemetry packet framer: payload bytes in, fixed 44-byte packets out (start marker,
// type id, sequence number, 40 payload bytes zero padded after a byte marked last,
// reflected CRC-8/MAXIM). The back end emits one packet byte per cycle from its output
// register while the queue holds an entry and out_ready does not stall it; payload bytes
// are taken one per cycle into a four-entry queue and input stalls once the queue fills
// while the header, padding and CRC bytes go out. A transfer in passes through the queue
// memory and the output register. Register writes take effect from the next packet start.
module telemetry_packet_framer_crc8_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [tpfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           payload_valid,
    output logic                           payload_ready,
    input  logic [7:0]                     payload_byte,
    input  logic                           payload_last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     out_byte,
    output logic                           packet_end
);

    logic             q_full;
    logic             q_push;
    tpfc_pkg::entry_t q_entry;
    logic             q_pop;
    logic             head_valid;
    tpfc_pkg::entry_t head_entry;

    tpfc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .payload_valid (payload_valid),
        .payload_ready (payload_ready),
        .payload_byte  (payload_byte),
        .payload_last  (payload_last),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_entry)
    );

    tpfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    tpfc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .packet_end (packet_end)
    );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int LONG_HOLD  = 300;
    localparam int IDLE_LIMIT = 3000;
    localparam int RANDOM_BYTES = 50;
    localparam logic [tpfc_pkg::CFG_IDX_W-1:0] REG_UNUSED =
        tpfc_pkg::CFG_IDX_W'(tpfc_pkg::NUM_REGS);

    typedef struct packed {
        logic [7:0] data;
        logic       closes;
    } framed_byte_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_write;
    logic [tpfc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [7:0]                     cfg_data;
    logic                           payload_valid;
    logic                           payload_ready;
    logic [7:0]                     payload_byte;
    logic                           payload_last;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [7:0]                     out_byte;
    logic                           packet_end;

    logic [7:0] marker_cfg = tpfc_pkg::START_MARKER_RST;
    logic [7:0] id_a_cfg   = tpfc_pkg::TYPE_A_ID_RST;
    logic [7:0] id_b_cfg   = tpfc_pkg::TYPE_B_ID_RST;
    logic       packet_open = 1'b0;
    int         payload_taken = 0;
    logic [7:0] crc_acc = tpfc_pkg::CRC_INIT;
    logic [7:0] seq_no = 8'h00;
    logic       id_b_next = 1'b0;

    framed_byte_t framed_bytes_due[$];
    framed_byte_t due_byte;

    int  errors = 0;
    int  bytes_sent = 0;
    int  bytes_checked = 0;
    int  packets_checked = 0;
    int  stalled_cycles = 0;
    int  rx_hold = 0;
    int  hold_requests = 0;
    int  hold_served = 0;
    bit  steady = 1'b0;

    always #5 clk = ~clk;

    telemetry_packet_framer_crc8_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .payload_valid (payload_valid),
        .payload_ready (payload_ready),
        .payload_byte  (payload_byte),
        .payload_last  (payload_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .packet_end    (packet_end)
    );

    function automatic logic [7:0] crc8_maxim_next(input logic [7:0] crc,
                                                  input logic [7:0] data);
        logic [7:0] r;
        r = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ tpfc_pkg::CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function void put_framed(input logic [7:0] data, input logic closes);
        framed_byte_t fb;
        fb.data   = data;
        fb.closes = closes;
        framed_bytes_due.push_back(fb);
        if (!closes)
        begin
            crc_acc = crc8_maxim_next(crc_acc, data);
        end
    endfunction

    function void frame_payload_byte(input logic [7:0] data, input logic last);
        if (!packet_open)
        begin
            crc_acc       = tpfc_pkg::CRC_INIT;
            payload_taken = 0;
            seq_no        = seq_no + 8'd1;
            put_framed(marker_cfg, 1'b0);
            put_framed(id_b_next ? id_b_cfg : id_a_cfg, 1'b0);
            put_framed(seq_no, 1'b0);
            packet_open = 1'b1;
        end
        put_framed(data, 1'b0);
        payload_taken++;
        if (last || payload_taken >= tpfc_pkg::PAYLOAD_LEN)
        begin
            while (payload_taken < tpfc_pkg::PAYLOAD_LEN)
            begin
                put_framed(8'h00, 1'b0);
                payload_taken++;
            end
            put_framed(crc_acc, 1'b1);
            packet_open   = 1'b0;
            payload_taken = 0;
            id_b_next     = ~id_b_next;
        end
    endfunction

    function automatic int idle_gap();
        int r;
        if (steady)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic push_payload(input logic [7:0] data, input logic last);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            payload_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        payload_valid <= 1'b1;
        payload_byte  <= data;
        payload_last  <= last;
        do
        begin
            @(posedge clk);
        end
        while (!payload_ready);
        frame_payload_byte(data, last);
        bytes_sent++;
    endtask

    task automatic send_packet(input int len, input bit mark_last);
        for (int i = 0; i < len; i++)
        begin
            push_payload(8'($urandom), mark_last && (i == len - 1));
        end
    endtask

    task automatic wait_packets_out();
        payload_valid <= 1'b0;
        while (framed_bytes_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [tpfc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            tpfc_pkg::REG_START_MARKER: marker_cfg = value;
            tpfc_pkg::REG_TYPE_A_ID:    id_a_cfg   = value;
            tpfc_pkg::REG_TYPE_B_ID:    id_b_cfg   = value;
            default:                    ;
        endcase
    endtask

    task automatic write_all_regs(input logic [7:0] marker, input logic [7:0] id_a,
                                  input logic [7:0] id_b);
        write_reg(tpfc_pkg::REG_START_MARKER, marker);
        write_reg(tpfc_pkg::REG_TYPE_A_ID, id_a);
        write_reg(tpfc_pkg::REG_TYPE_B_ID, id_b);
    endtask

    task automatic test_payload_extremes();
        push_payload(8'h00, 1'b0);
        push_payload(8'hFF, 1'b0);
        push_payload(8'h55, 1'b0);
        push_payload(8'hAA, 1'b1);
        push_payload(8'h01, 1'b1);
        push_payload(8'h80, 1'b1);
    endtask

    task automatic test_full_payload();
        send_packet(tpfc_pkg::PAYLOAD_LEN, 1'b0);
        send_packet(tpfc_pkg::PAYLOAD_LEN, 1'b1);
    endtask

    task automatic test_register_extremes();
        wait_packets_out();
        write_all_regs(8'h00, 8'h00, 8'h00);
        send_packet(2, 1'b1);
        send_packet(1, 1'b1);
        wait_packets_out();
        write_all_regs(8'hFF, 8'hFF, 8'hFF);
        send_packet(2, 1'b1);
        send_packet(1, 1'b1);
        wait_packets_out();
        write_reg(REG_UNUSED, 8'h00);
        send_packet(1, 1'b1);
        wait_packets_out();
        write_all_regs(tpfc_pkg::START_MARKER_RST, tpfc_pkg::TYPE_A_ID_RST,
                       tpfc_pkg::TYPE_B_ID_RST);
    endtask

    task automatic test_write_mid_packet();
        send_packet(5, 1'b0);
        wait_packets_out();
        write_all_regs(8'h3C, 8'h5A, 8'hA5);
        send_packet(3, 1'b1);
        send_packet(2, 1'b1);
    endtask

    task automatic test_back_pressure();
        steady = 1'b1;
        hold_requests++;
        send_packet(tpfc_pkg::PAYLOAD_LEN, 1'b0);
        send_packet(3, 1'b1);
        steady = 1'b0;
        wait_packets_out();
    endtask

    task automatic test_random_traffic();
        int first;
        int kind;
        first = bytes_sent;
        while (bytes_sent - first < RANDOM_BYTES)
        begin
            kind   = $urandom_range(0, 11);
            steady = ($urandom_range(0, 4) == 0);
            if (kind < 6)
            begin
                send_packet($urandom_range(1, 6), 1'b1);
            end
            else if (kind == 6)
            begin
                send_packet(tpfc_pkg::PAYLOAD_LEN, 1'b0);
            end
            else if (kind == 7)
            begin
                send_packet(tpfc_pkg::PAYLOAD_LEN, 1'b1);
            end
            else if (kind < 10)
            begin
                send_packet($urandom_range(7, tpfc_pkg::PAYLOAD_LEN - 1), 1'b1);
            end
            else if (kind == 10)
            begin
                send_packet($urandom_range(1, 5), 1'b0);
            end
            else
            begin
                wait_packets_out();
                write_reg(tpfc_pkg::CFG_IDX_W'($urandom_range(0, tpfc_pkg::NUM_REGS)),
                          8'($urandom));
            end
        end
        steady = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            rx_hold     <= LONG_HOLD;
            out_ready   <= 1'b0;
        end
        else if (rx_hold > 0)
        begin
            rx_hold   <= rx_hold - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            rx_hold   <= idle_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (framed_bytes_due.size() == 0)
            begin
                $error("unexpected transfer: out_byte %h packet_end %b", out_byte, packet_end);
                errors++;
            end
            else
            begin
                due_byte = framed_bytes_due.pop_front();
                if (out_byte !== due_byte.data)
                begin
                    $error("out_byte: expected %h, actual %h", due_byte.data, out_byte);
                    errors++;
                end
                if (packet_end !== due_byte.closes)
                begin
                    $error("packet_end: expected %b, actual %b", due_byte.closes, packet_end);
                    errors++;
                end
            end
            bytes_checked++;
            if (packet_end === 1'b1)
            begin
                packets_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (payload_valid && payload_ready) || (out_valid && out_ready))
        begin
            stalled_cycles <= 0;
        end
        else if (stalled_cycles >= IDLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
        else
        begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = tpfc_pkg::REG_START_MARKER;
        cfg_data      = 8'h00;
        payload_valid = 1'b0;
        payload_byte  = 8'h00;
        payload_last  = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_payload_extremes();
        test_full_payload();
        test_register_extremes();
        test_write_mid_packet();
        test_back_pressure();
        test_random_traffic();

        wait_packets_out();
        repeat (10) @(posedge clk);
        if (framed_bytes_due.size() != 0)
        begin
            $error("%0d framed bytes never arrived", framed_bytes_due.size());
            errors++;
        end

        $display("summary: %0d payload bytes in, %0d framed bytes checked in %0d packets",
                 bytes_sent, bytes_checked, packets_checked);
        $display("summary: register extremes, mid-packet writes, long stall, full and padded");
        if (errors == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// File: telemetry_packet_framer_crc8_unit.f
rtl/tpfc_pkg.sv
rtl/tpfc_front.sv
rtl/tpfc_queue.sv
rtl/tpfc_back.sv
rtl/telemetry_packet_framer_crc8_unit.sv
bench/testbench.sv
